/* rtl/swcg_pkg.sv */
// Shared types, constants and a helper function of the sliding-window chord guesser.
package swcg_pkg;

    localparam int PITCH_CLASSES = 12;
    localparam int MINOR_THIRD   = 3;
    localparam int NOTE_W        = 8;
    localparam int ROOT_W        = 4;

    // Item kinds carried on the input tuser bit
    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    // Chord guess passed from the picker to the top level
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              minor;
    } t_chord;

    // note mod 12 via reciprocal multiply: floor(note/12) = (note*171) >> 11 for 8-bit notes
    function automatic logic [ROOT_W-1:0] pitch_class(input logic [NOTE_W-1:0] note);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        prod = 16'(note) * 16'd171;
        quot = prod[15:11];
        rem  = note - (8'(quot) * 8'd12);
        return rem[ROOT_W-1:0];
    endfunction

endpackage

/* rtl/sliding_window_chord_guess.sv */
// Sliding-window chord guesser: note histogram over the last notes and chord pick.
//
// Input stream (s side): each word is either a note to add (tuser = 0, note in
// tdata[7:0]) or a clear of the window (tuser = 1, tdata ignored). Every
// accepted word yields exactly one result word on the m side: chord root
// (0 = C), minor flag and the number of pitch classes now held.
// The window keeps the last WINDOW_DEPTH pitch classes; once full, each new note
// evicts the oldest. The histogram is updated at the accept edge, and the chord is
// picked from it into the result register once that register is free.
// One word per cycle is sustained while the receiver keeps taking results; the
// 12-way argmax sits between the histogram and result registers.
// An empty window (after a clear) keeps the previous chord.
// Reset (synchronous, i_rst_n low) empties the window, zeroes the counters and
// sets the held chord to C major. If the receiver stalls, the result word holds
// and one more word is taken into the histogram stage; o_s_tready then drops
// until the output drains.
module sliding_window_chord_guess #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] note
    input  logic       i_s_tuser,   // [0] command: 0 add note, 1 clear
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    // [3:0] chord_root, [4] chord_minor, [5 +: FILL_W] held_count, zero pad above
    output logic [((5 + $clog2(WINDOW_DEPTH + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);
    import swcg_pkg::*;

    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int OUT_W   = ROOT_W + 1 + FILL_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Histogram stage state
    logic [ROOT_W-1:0] r_window [WINDOW_DEPTH];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_counts [PITCH_CLASSES];
    logic [FILL_W-1:0] n_counts [PITCH_CLASSES];
    logic              r_s1_valid;

    // Output stage
    t_chord            r_held;
    logic [ROOT_W-1:0] r_out_root;
    logic              r_out_minor;
    logic [FILL_W-1:0] r_out_count;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_advance;
    logic              w_clear;
    logic              w_full;
    logic [ROOT_W-1:0] w_pc;
    logic [ROOT_W-1:0] w_old;
    t_chord            w_pick;
    t_chord            w_chord;

    // Handshake: output register frees when empty or taken
    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = w_advance || !r_s1_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_clear    = (t_cmd'(i_s_tuser) == CMD_CLEAR);
    assign w_full     = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign w_pc       = pitch_class(i_s_tdata);
    assign w_old      = r_window[WINDOW_DEPTH-1];

    // Incremental histogram and fill update
    always_comb begin
        n_fill = r_fill;
        for (int i = 0; i < PITCH_CLASSES; i++) begin
            n_counts[i] = r_counts[i];
        end
        if (w_accept) begin
            if (w_clear) begin
                n_fill = '0;
                for (int i = 0; i < PITCH_CLASSES; i++) begin
                    n_counts[i] = '0;
                end
            end else begin
                if (!w_full) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                for (int i = 0; i < PITCH_CLASSES; i++) begin
                    n_counts[i] = r_counts[i]
                                + FILL_W'(w_pc == ROOT_W'(i))
                                - FILL_W'(w_full && (w_old == ROOT_W'(i)));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            for (int i = 0; i < PITCH_CLASSES; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_fill <= n_fill;
            for (int i = 0; i < PITCH_CLASSES; i++) begin
                r_counts[i] <= n_counts[i];
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Window as a shift line: once full, the oldest class sits in the last tap
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_clear) begin
            r_window[0] <= w_pc;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_window[i] <= r_window[i-1];
            end
        end
    end

    swcg_chord_pick #(
        .CNT_W (FILL_W)
    ) u_pick (
        .i_counts (r_counts),
        .o_chord  (w_pick)
    );

    // An empty window keeps the previous chord
    assign w_chord = (r_fill != '0) ? w_pick : r_held;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_held <= w_chord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out_root  <= w_chord.root;
            r_out_minor <= w_chord.minor;
            r_out_count <= r_fill;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'({r_out_count, r_out_minor, r_out_root});

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_clear |=> r_fill == '0)
        else $error("clear did not empty the window");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_clear && !w_full |=> r_fill == $past(r_fill) + FILL_W'(1))
        else $error("add to a non-full window did not grow it");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while both stages are blocked");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_root < ROOT_W'(PITCH_CLASSES))
        else $error("chord root out of range");
`endif

endmodule

/* rtl/swcg_chord_pick.sv */
// Picks the most frequent pitch class (lowest on ties) and its minor-third flag.
module swcg_chord_pick #(
    parameter int CNT_W = 5
) (
    input  logic [CNT_W-1:0] i_counts [swcg_pkg::PITCH_CLASSES],
    output swcg_pkg::t_chord o_chord
);
    import swcg_pkg::*;

    // Tree levels: 12 -> 6 -> 3 -> 2 -> 1, left operand wins ties to keep the lower class
    logic [CNT_W-1:0]  w_l1_cnt [6];
    logic [ROOT_W-1:0] w_l1_idx [6];
    logic [CNT_W-1:0]  w_l2_cnt [3];
    logic [ROOT_W-1:0] w_l2_idx [3];
    logic [CNT_W-1:0]  w_l3_cnt [2];
    logic [ROOT_W-1:0] w_l3_idx [2];
    logic [ROOT_W-1:0] w_key;
    logic [ROOT_W-1:0] w_third;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            if (i_counts[2*i+1] > i_counts[2*i]) begin
                w_l1_cnt[i] = i_counts[2*i+1];
                w_l1_idx[i] = ROOT_W'(2*i+1);
            end else begin
                w_l1_cnt[i] = i_counts[2*i];
                w_l1_idx[i] = ROOT_W'(2*i);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (w_l1_cnt[2*i+1] > w_l1_cnt[2*i]) begin
                w_l2_cnt[i] = w_l1_cnt[2*i+1];
                w_l2_idx[i] = w_l1_idx[2*i+1];
            end else begin
                w_l2_cnt[i] = w_l1_cnt[2*i];
                w_l2_idx[i] = w_l1_idx[2*i];
            end
        end
        if (w_l2_cnt[1] > w_l2_cnt[0]) begin
            w_l3_cnt[0] = w_l2_cnt[1];
            w_l3_idx[0] = w_l2_idx[1];
        end else begin
            w_l3_cnt[0] = w_l2_cnt[0];
            w_l3_idx[0] = w_l2_idx[0];
        end
        w_l3_cnt[1] = w_l2_cnt[2];
        w_l3_idx[1] = w_l2_idx[2];
        if (w_l3_cnt[1] > w_l3_cnt[0]) begin
            w_key = w_l3_idx[1];
        end else begin
            w_key = w_l3_idx[0];
        end
    end

    // Minor third above the key, wrapped within the octave
    always_comb begin
        if (w_key >= ROOT_W'(PITCH_CLASSES - MINOR_THIRD)) begin
            w_third = w_key - ROOT_W'(PITCH_CLASSES - MINOR_THIRD);
        end else begin
            w_third = w_key + ROOT_W'(MINOR_THIRD);
        end
    end

    always_comb begin
        o_chord.root  = w_key;
        o_chord.minor = 1'b0;
        for (int i = 0; i < PITCH_CLASSES; i++) begin
            if (w_third == ROOT_W'(i)) begin
                o_chord.minor = (i_counts[i] != '0);
            end
        end
    end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the sliding-window chord guesser.
`timescale 1ns / 1ps

module tb_top;
    import swcg_pkg::*;

    localparam int WINDOW_DEPTH = 16;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int OUT_W        = ((5 + FILL_W + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 1650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOWN_FAILS  = 10;

    // One result word split into its fields
    typedef struct packed {
        logic [FILL_W-1:0] held;
        logic              minor;
        logic [ROOT_W-1:0] root;
    } t_guess;

    // Tracks the window and histogram and keeps the guesses still owed by the DUT
    class chord_scoreboard;
        logic [ROOT_W-1:0] window_pc[WINDOW_DEPTH];
        int unsigned       oldest;
        int unsigned       fill;
        int unsigned       counts[PITCH_CLASSES];
        logic [ROOT_W-1:0] root;
        logic              minor;
        t_guess            owed_guesses[$];
        int unsigned       fails;

        function new();
            oldest = 0;
            fill   = 0;
            root   = '0;
            minor  = 1'b0;
            fails  = 0;
            foreach (counts[i]) counts[i] = 0;
        endfunction

        function void flag_fail(string what, t_guess want, t_guess got);
            fails++;
            if (fails <= SHOWN_FAILS)
                $display({"mismatch %s: expected root %0d minor %0d held %0d, ",
                          "got root %0d minor %0d held %0d"},
                         what, want.root, want.minor, want.held, got.root, got.minor, got.held);
        endfunction

        // Update the window for one accepted word and queue its chord guess
        function void accept_word(t_cmd cmd, logic [NOTE_W-1:0] note);
            int unsigned slot;
            int unsigned pc;
            int unsigned best;
            int unsigned key;
            t_guess      g;
            if (cmd == CMD_CLEAR) begin
                oldest = 0;
                fill   = 0;
                foreach (counts[i]) counts[i] = 0;
            end else begin
                pc = note % PITCH_CLASSES;
                if (fill < WINDOW_DEPTH) begin
                    slot = (oldest + fill) % WINDOW_DEPTH;
                    fill++;
                end else begin
                    // full: overwrite the oldest and drop its count
                    slot = oldest;
                    if (counts[window_pc[slot]] > 0) counts[window_pc[slot]]--;
                    oldest = (slot + 1) % WINDOW_DEPTH;
                end
                window_pc[slot] = ROOT_W'(pc);
                counts[pc]++;
            end
            // empty window keeps the previous chord
            if (fill != 0) begin
                best = 0;
                key  = 0;
                for (int i = 0; i < PITCH_CLASSES; i++)
                    if (counts[i] > best) begin
                        best = counts[i];
                        key  = i;
                    end
                root  = ROOT_W'(key);
                minor = counts[(key + MINOR_THIRD) % PITCH_CLASSES] > 0;
            end
            g.root  = root;
            g.minor = minor;
            g.held  = FILL_W'(fill);
            owed_guesses.push_back(g);
        endfunction

        // Compare one result word with the oldest owed guess
        function void check_result(logic [OUT_W-1:0] word);
            t_guess got;
            t_guess want;
            got = word[5 + FILL_W - 1:0];
            if (owed_guesses.size() == 0) begin
                fails++;
                if (fails <= SHOWN_FAILS)
                    $display("unexpected result word root %0d minor %0d held %0d",
                             got.root, got.minor, got.held);
                return;
            end
            want = owed_guesses.pop_front();
            if (got.root != want.root) flag_fail("root", want, got);
            else if (got.minor != want.minor) flag_fail("minor", want, got);
            else if (got.held != want.held) flag_fail("held_count", want, got);
        endfunction

        function int unsigned owed();
            return owed_guesses.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;   // [7:0] note
    logic             i_s_tuser;   // [0] command
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;   // [3:0] root, [4] minor, [9:5] held_count

    chord_scoreboard sb;
    bit              calm;
    int unsigned     cycles;

    sliding_window_chord_guess #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls at random outside the calm stretch
    always @(negedge i_clk)
        i_m_tready = calm || ($urandom_range(0, 99) >= 27);

    // result monitor
    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);

    // Drive one word; called and returns at a falling edge
    task automatic send_word(input t_cmd cmd, input logic [7:0] note);
        while (!calm && $urandom_range(0, 99) < 27) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = note;
        do @(posedge i_clk); while (!o_s_tready);
        sb.accept_word(cmd, note);
        @(negedge i_clk);
    endtask

    // note whose pitch class is pc, in a random octave
    function automatic logic [7:0] note_of(int unsigned pc);
        return 8'(pc + PITCH_CLASSES * $urandom_range(0, 20));
    endfunction

    initial begin
        int unsigned chord_root;
        int unsigned third;
        int unsigned run_len;
        int unsigned sent;
        int unsigned pick;
        sb         = new();
        calm       = 1'b0;
        cycles     = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = CMD_ADD;
        i_m_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: clear on an empty window, field extremes, tie, wrap of the third
        send_word(CMD_CLEAR, 8'h00);
        send_word(CMD_ADD, 8'hFF);
        send_word(CMD_ADD, 8'h00);
        send_word(CMD_ADD, 8'd11);
        send_word(CMD_ADD, 8'd23);
        send_word(CMD_ADD, 8'd2);
        send_word(CMD_CLEAR, 8'hFF);
        // overfill the window so the oldest entries get evicted
        for (int i = 0; i < WINDOW_DEPTH + 2; i++)
            send_word(CMD_ADD, 8'(128 + 7 * i));

        // hold off until the DUT has drained everything
        i_s_tvalid = 1'b0;
        while (sb.owed() != 0) @(negedge i_clk);

        // random: runs of chord-shaped notes with some noise and clears
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            calm       = (sent >= 700 && sent < 900);
            chord_root = $urandom_range(0, PITCH_CLASSES - 1);
            third      = $urandom_range(0, 1) ? 3 : 4;
            run_len    = $urandom_range(4, 40);
            for (int k = 0; k < run_len && sent < RANDOM_WORDS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
                else if (pick < 20)
                    send_word(CMD_ADD, 8'($urandom_range(0, 255)));
                else if (pick < 50)
                    send_word(CMD_ADD, note_of(chord_root));
                else if (pick < 75)
                    send_word(CMD_ADD, note_of((chord_root + third) % PITCH_CLASSES));
                else
                    send_word(CMD_ADD, note_of((chord_root + 7) % PITCH_CLASSES));
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
        end
        calm       = 1'b0;
        i_s_tvalid = 1'b0;

        // drain, then let a few more cycles pass for stray words
        while (sb.owed() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0 && sb.owed() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
